### design/rspd_pkg.sv
// ----------------------------------------------------------------------------
// rspd_pkg: shared types and constants for the packet receive deframer
// Framing characters, result codes and the result record.
// ----------------------------------------------------------------------------
package rspd_pkg;

  localparam logic [7:0] CH_START = 8'h24;  // '$'
  localparam logic [7:0] CH_END   = 8'h23;  // '#'
  localparam logic [7:0] CH_INTR  = 8'h03;  // break

  localparam int unsigned TDATA_W = 32;

  typedef enum logic [1:0] {
    KIND_BODY = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_BAD  = 2'd2,
    KIND_INTR = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ACK_NONE  = 2'd0,
    ACK_PLUS  = 2'd1,
    ACK_MINUS = 2'd2
  } ack_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    ack_t        ack;
    logic [15:0] len;
  } result_t;

endpackage

### design/rspd_in_stage.sv
// ----------------------------------------------------------------------------
// rspd_in_stage: input register
// Holds one received byte until the core consumes it.
// ----------------------------------------------------------------------------
module rspd_in_stage
  import rspd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       advance,
  output logic       byte_valid,
  output logic [7:0] rx_byte
);

  assign s_tready = !byte_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      byte_valid <= 1'b1;
    end else if (advance) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      rx_byte <= s_tdata;
    end
  end

endmodule

### design/rspd_core.sv
// ----------------------------------------------------------------------------
// rspd_core: framing state machine
// Tracks $body#hh framing, running checksum and body length, and builds
// the result for the byte in the input register.
// ----------------------------------------------------------------------------
module rspd_core
  import rspd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       byte_valid,
  input  logic [7:0] rx_byte,
  input  logic       out_free,
  output logic       advance,
  output logic       load,
  output result_t    res
);

  typedef enum logic [1:0] {
    PH_WAIT  = 2'd0,
    PH_BODY  = 2'd1,
    PH_CS_HI = 2'd2,
    PH_CS_LO = 2'd3
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [3:0]  high_digit, high_digit_next;
  logic [15:0] length_count, length_count_next;
  logic        no_ack_mode;
  logic        produce;
  logic [3:0]  digit;
  logic [7:0]  got;
  logic        good;

  // hex digit decode, anything else counts as zero
  always_comb begin
    if (rx_byte >= 8'h30 && rx_byte <= 8'h39) begin
      digit = 4'(rx_byte - 8'h30);
    end else if (rx_byte >= 8'h61 && rx_byte <= 8'h66) begin
      digit = 4'(rx_byte - 8'h57);
    end else if (rx_byte >= 8'h41 && rx_byte <= 8'h46) begin
      digit = 4'(rx_byte - 8'h37);
    end else begin
      digit = 4'd0;
    end
  end

  assign got  = {high_digit, digit};
  assign good = (got == running_sum);

  always_comb begin
    phase_next        = phase;
    running_sum_next  = running_sum;
    high_digit_next   = high_digit;
    length_count_next = length_count;
    produce           = 1'b0;
    res               = '{kind: KIND_BODY, data: 8'd0, ack: ACK_NONE, len: 16'd0};
    unique case (phase)
      PH_WAIT: begin
        if (rx_byte == CH_START) begin
          running_sum_next  = 8'd0;
          length_count_next = 16'd0;
          phase_next        = PH_BODY;
        end else if (rx_byte == CH_INTR) begin
          produce  = 1'b1;
          res.kind = KIND_INTR;
        end
      end
      PH_BODY: begin
        if (rx_byte == CH_END) begin
          phase_next = PH_CS_HI;
        end else begin
          running_sum_next = running_sum + rx_byte;
          if (length_count != 16'hFFFF) begin
            length_count_next = length_count + 16'd1;
          end
          produce  = 1'b1;
          res.data = rx_byte;
        end
      end
      PH_CS_HI: begin
        high_digit_next = digit;
        phase_next      = PH_CS_LO;
      end
      PH_CS_LO: begin
        produce  = 1'b1;
        res.kind = good ? KIND_GOOD : KIND_BAD;
        res.data = got;
        res.len  = length_count;
        if (!no_ack_mode) begin
          res.ack = good ? ACK_PLUS : ACK_MINUS;
        end
        phase_next        = PH_WAIT;
        running_sum_next  = 8'd0;
        length_count_next = 16'd0;
      end
      default: begin
        phase_next = PH_WAIT;
      end
    endcase
  end

  // a byte with no result never waits on the output side
  assign advance = byte_valid && (!produce || out_free);
  assign load    = advance && produce;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_WAIT;
      running_sum  <= 8'd0;
      high_digit   <= 4'd0;
      length_count <= 16'd0;
      no_ack_mode  <= 1'b0;
    end else begin
      if (advance) begin
        phase        <= phase_next;
        running_sum  <= running_sum_next;
        high_digit   <= high_digit_next;
        length_count <= length_count_next;
      end
      if (cfg_we) begin
        no_ack_mode <= cfg_wdata;
      end
    end
  end

endmodule

### design/rspd_out_stage.sv
// ----------------------------------------------------------------------------
// rspd_out_stage: result register
// Holds one result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module rspd_out_stage
  import rspd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  result_t            res,
  output logic               out_free,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,
  output logic [1:0]         m_tuser
);

  result_t held;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign m_tdata = {6'd0, held.len, held.ack, held.data};
  assign m_tuser = held.kind;

endmodule

### design/rsp_packet_receive_deframer_top.sv
// ----------------------------------------------------------------------------
// rsp_packet_receive_deframer_top: remote debug packet receive deframer
// Deframes $body#hh packets from a received byte stream.
// ----------------------------------------------------------------------------
// One received byte per beat enters on the slave side; a byte can be
// accepted in every cycle while the master side is ready. Each byte
// passes through the input register, then the framing state machine into
// the result register. Body bytes come out as they arrive
// (kind 0), followed by a good/bad verdict carrying the received checksum,
// body length and the ack to send; the body must be dropped on a bad
// verdict. A break byte (0x03) while idle gives an interrupt beat. Setting
// cfg_wdata to 1 with cfg_we suppresses ack requests; write only while idle.
module rsp_packet_receive_deframer_top
  import rspd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_wdata,   // no_ack_mode
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,     // [7:0] rx_byte
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,     // [7:0] data_byte, [9:8] ack_to_send,
                                          // [25:10] body_length, rest zero
  output logic [1:0]         m_tuser      // [1:0] event_kind
);

  logic       byte_valid;
  logic [7:0] rx_byte;
  logic       advance;
  logic       load;
  logic       out_free;
  result_t    res;

  rspd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .advance    (advance),
    .byte_valid (byte_valid),
    .rx_byte    (rx_byte)
  );

  rspd_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .byte_valid (byte_valid),
    .rx_byte    (rx_byte),
    .out_free   (out_free),
    .advance    (advance),
    .load       (load),
    .res        (res)
  );

  rspd_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .res      (res),
    .out_free (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
